@@ sv/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the range min/max segment tree.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int MAX_ELEMENTS = 1024;

   localparam int COUNT_W = 11;
   localparam int VAL_W   = 32;
   localparam int ADDR_W  = 3;

   localparam logic [ADDR_W-1:0] REG_COUNT_ADDR = 3'd0;

   localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;

   // request command carried on tuser
   typedef enum logic { CMD_WRITE = 1'b0, CMD_QUERY = 1'b1 } cmd_type;

   // one tree node: min in the low half, max in the high half
   typedef struct packed {
      logic signed [VAL_W-1:0] max;
      logic signed [VAL_W-1:0] min;
   } node_type;

endpackage

@@ sv/rmq_mem.sv @@
// ----------------------------------------------------------------------------
// rmq_mem
// Node store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rmq_mem #(
   parameter int AW = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  rmq_pkg::node_type wr_data,
   input  logic [AW-1:0]     rd_addr_a,
   input  logic [AW-1:0]     rd_addr_b,
   output rmq_pkg::node_type rd_data_a,
   output rmq_pkg::node_type rd_data_b
);
   import rmq_pkg::*;

   node_type mem [2**AW];
   node_type rd_a_ff;
   node_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ sv/rmq_minmax.sv @@
// ----------------------------------------------------------------------------
// rmq_minmax
// Shared combine unit: signed min of mins and max of maxes.
// ----------------------------------------------------------------------------
module rmq_minmax (
   input  rmq_pkg::node_type a,
   input  rmq_pkg::node_type b,
   output rmq_pkg::node_type y
);
   import rmq_pkg::*;

   always_comb begin
      y.min = (a.min < b.min) ? a.min : b.min;
      y.max = (a.max > b.max) ? a.max : b.max;
   end

endmodule

@@ sv/range_min_max_query_tree_unit.sv @@
// ----------------------------------------------------------------------------
// range_min_max_query_tree_unit
// Segment tree of signed minimums and maximums with point writes and
// inclusive range queries.
// ----------------------------------------------------------------------------
// Input words arrive on req_*; tuser is the command (0 write, 1 query).
// A write stores a value at a position and refreshes its ancestors; it
// gives no output word. A query returns min and max over [left, right]
// on rsp_*. The user must set element_count through the csr_* port only
// while idle; the block does not enforce this. Structure: one node store
// with two read ports and one shared min/max unit. A write descends level
// by level to the leaf and writes it, then climbs, reading both children
// of each ancestor and then writing their combination. A query visits
// nodes depth first with a small stack; a covered node takes an extra
// accumulate step, and a final step loads the result.
// req_tready is high only while the sequencer is idle. A finished result
// sits in the output register; the next word can be accepted meanwhile,
// and a second query waits at its end until the register is taken.
// Reset clears the control state and sets element_count to MAX_ELEMENTS;
// tree contents are undefined until written (no clearing pass).
// ----------------------------------------------------------------------------
module range_min_max_query_tree_unit (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: position[10:0], elem_value[42:11], range_left[53:43],
   //            range_right[64:54], zero fill
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [71:0]                 req_tdata,
   input  logic                        req_tuser,   // cmd
   // rsp_tdata: range_min[31:0], range_max[63:32]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [63:0]                 rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rmq_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import rmq_pkg::*;

   localparam int PW  = ($clog2(MAX_ELEMENTS + 1) > COUNT_W) ?
                        $clog2(MAX_ELEMENTS + 1) : COUNT_W;
   localparam int NW  = $clog2(MAX_ELEMENTS) + 1;
   localparam int SD  = NW + 1;
   localparam int SIW = $clog2(SD);
   localparam int SPW = $clog2(SD + 1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_WDESC = 7'b0000010,
      ST_WRD   = 7'b0000100,
      ST_WCMB  = 7'b0001000,
      ST_QVIS  = 7'b0010000,
      ST_QACC  = 7'b0100000,
      ST_QFIN  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [NW-1:0] node;
      logic [PW-1:0] s;
      logic [PW-1:0] e;
   } frame_type;

   state_type          state_ff, state_in;
   frame_type          cur_ff, cur_in;
   frame_type          stk_ff [SD];
   logic [SPW-1:0]     sp_ff, sp_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [PW-1:0]      left_ff, left_in;
   logic [PW-1:0]      right_ff, right_in;
   logic [VAL_W-1:0]   val_ff, val_in;
   node_type           acc_ff, acc_in;
   logic [COUNT_W-1:0] count_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   node_type           rsp_data_ff, rsp_data_in;

   logic               push;
   logic [PW-1:0]      cnt_ext, n_eff, mid;
   logic [PW:0]        sum;
   logic [NW-1:0]      lchild, rchild;
   logic               disjoint, covered, pop_ok, fin_ok, accept;
   logic [PW-1:0]      req_pos, req_left, req_right;

   logic               mem_we;
   logic [NW-1:0]      mem_wa, mem_ra_a;
   node_type           mem_wd, rd_a, rd_b, cmp_a, cmp_b, cmp_y;

   // ---------------- config port
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(32-COUNT_W){1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(MAX_ELEMENTS);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == REG_COUNT_ADDR) begin
         count_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   assign cnt_ext = PW'(count_ff);
   always_comb begin
      if (count_ff == '0) begin
         n_eff = PW'(1);
      end else if (cnt_ext > PW'(MAX_ELEMENTS)) begin
         n_eff = PW'(MAX_ELEMENTS);
      end else begin
         n_eff = cnt_ext;
      end
   end

   // ---------------- datapath helpers
   assign req_pos   = PW'(req_tdata[10:0]);
   assign req_left  = PW'(req_tdata[53:43]);
   assign req_right = PW'(req_tdata[64:54]);

   assign sum    = {1'b0, cur_ff.s} + {1'b0, cur_ff.e};
   assign mid    = sum[PW:1];
   assign lchild = {cur_ff.node[NW-2:0], 1'b0};
   assign rchild = {cur_ff.node[NW-2:0], 1'b1};

   assign disjoint = (left_ff > cur_ff.e) || (right_ff < cur_ff.s);
   assign covered  = (left_ff <= cur_ff.s) && (cur_ff.e <= right_ff);
   assign pop_ok   = (sp_ff != '0);
   assign fin_ok   = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // shared combine unit
   assign cmp_a = (state_ff == ST_WCMB) ? rd_a : acc_ff;
   assign cmp_b = (state_ff == ST_WCMB) ? rd_b : rd_a;

   rmq_minmax u_minmax (
      .a (cmp_a),
      .b (cmp_b),
      .y (cmp_y)
   );

   assign mem_ra_a = (state_ff == ST_WRD) ? lchild : cur_ff.node;
   assign mem_wa   = cur_ff.node;
   assign mem_we   = ((state_ff == ST_WDESC) && (cur_ff.s == cur_ff.e)) ||
                     (state_ff == ST_WCMB);
   always_comb begin
      if (state_ff == ST_WCMB) begin
         mem_wd = cmp_y;
      end else begin
         mem_wd.min = val_ff;
         mem_wd.max = val_ff;
      end
   end

   rmq_mem #(.AW(NW)) u_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_wa),
      .wr_data   (mem_wd),
      .rd_addr_a (mem_ra_a),
      .rd_addr_b (rchild),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // ---------------- sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      sp_in        = sp_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      val_in       = val_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      push         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in.node = NW'(1);
               cur_in.s    = PW'(1);
               cur_in.e    = n_eff;
               sp_in       = '0;
               pos_in      = req_pos;
               val_in      = req_tdata[42:11];
               left_in     = req_left;
               right_in    = req_right;
               acc_in.min  = INT_MAX;
               acc_in.max  = INT_MIN;
               if (req_tuser == CMD_QUERY) begin
                  state_in = ST_QVIS;
               end else if (req_pos != '0 && req_pos <= n_eff) begin
                  state_in = ST_WDESC;
               end
            end
         end
         ST_WDESC: begin
            if (cur_ff.s == cur_ff.e) begin
               // leaf written this cycle; climb unless it is the root
               cur_in.node = cur_ff.node >> 1;
               state_in    = (cur_ff.node == NW'(1)) ? ST_IDLE : ST_WRD;
            end else if (pos_ff <= mid) begin
               cur_in.node = lchild;
               cur_in.e    = mid;
            end else begin
               cur_in.node = rchild;
               cur_in.s    = mid + PW'(1);
            end
         end
         ST_WRD: begin
            state_in = ST_WCMB;
         end
         ST_WCMB: begin
            cur_in.node = cur_ff.node >> 1;
            state_in    = (cur_ff.node == NW'(1)) ? ST_IDLE : ST_WRD;
         end
         ST_QVIS: begin
            if (disjoint) begin
               if (pop_ok) begin
                  cur_in = stk_ff[SIW'(sp_ff - SPW'(1))];
                  sp_in  = sp_ff - SPW'(1);
               end else begin
                  state_in = ST_QFIN;
               end
            end else if (covered) begin
               state_in = ST_QACC;
            end else begin
               push        = 1'b1;
               sp_in       = sp_ff + SPW'(1);
               cur_in.node = lchild;
               cur_in.e    = mid;
            end
         end
         ST_QACC: begin
            acc_in = cmp_y;
            if (pop_ok) begin
               cur_in   = stk_ff[SIW'(sp_ff - SPW'(1))];
               sp_in    = sp_ff - SPW'(1);
               state_in = ST_QVIS;
            end else begin
               state_in = ST_QFIN;
            end
         end
         ST_QFIN: begin
            if (fin_ok) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      pos_ff      <= pos_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      val_ff      <= val_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      if (push) begin
         stk_ff[SIW'(sp_ff)] <= '{node: rchild, s: mid + PW'(1), e: cur_ff.e};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- checks
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(SD))
      else $error("query stack overflow");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_QFIN))
      else $error("result raised outside query finish");

   a_visit_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QVIS || state_ff == ST_WDESC) |-> cur_ff.s <= cur_ff.e)
      else $error("node span inverted");

endmodule
